[rtl/spc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types and constants of the sprite pixel compositor.
// ----------------------------------------------------------------------------
package spc_pkg;

  typedef enum logic [1:0] {
    OP_TBL_WR = 2'd0,
    OP_TEX_WR = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  localparam int RECORD_BYTES = 12;

  // byte positions within a sprite record
  localparam int B_X_LO  = 0;
  localparam int B_X_HI  = 1;
  localparam int B_Y_LO  = 2;
  localparam int B_Y_HI  = 3;
  localparam int B_WM1   = 4;
  localparam int B_HM1   = 5;
  localparam int B_OFF0  = 6;
  localparam int B_OFF1  = 7;
  localparam int B_OFF2  = 8;
  localparam int B_FLAGS = 9;
  localparam int B_PRI   = 10;

  localparam logic [7:0] FLAG_VISIBLE = 8'h01;
  localparam logic [7:0] FLAG_FLIPX   = 8'h02;
  localparam logic [7:0] FLAG_FLIPY   = 8'h04;

  // addr / 12 as (addr * 2731) >> 15, exact for addr < 3072
  localparam logic [24:0] RECIP_12    = 25'd2731;
  localparam int          RECIP_SHIFT = 15;

endpackage

[rtl/spc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module spc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sprite_pixel_compositor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_pixel_compositor
// Sprite table and texel store with a priority scan per pixel query.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                 Payload
// s_axis   in   s_axis_tvalid/tready      tuser: op; tdata: addr,data,qx,qy
// m_axis   out  m_axis_tvalid/tready      tdata: hit,color,winner
// cfg      in   cfg_valid_i/cfg_ready_o   cfg_data_i: transparent index
//
// Table and texel writes are stored as soon as the word is taken.
// A query reads one table row per cycle through a four-stage decode / address /
// texel-read pipeline, then the result is loaded; no word is taken until then.
// After reset the table is zeroed row by row; no word is taken then.
// A finished result waits in the output register; new words are still taken.
// ----------------------------------------------------------------------------
module sprite_pixel_compositor
  import spc_pkg::*;
#(
  parameter int SPRITE_COUNT  = 256,
  parameter int TEX_ADDR_BITS = 18
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // addr[17:0] data[25:18] query_x[41:26] query_y[57:42]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // hit[0] color[8:1] winner[16:9]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  localparam int IDX_W = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
  localparam int CNT_W = $clog2(SPRITE_COUNT + 1);
  localparam int TAW   = TEX_ADDR_BITS;
  localparam logic [17:0]      TABLE_BYTES = 18'(SPRITE_COUNT * RECORD_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST    = CNT_W'(SPRITE_COUNT - 1);
  localparam logic [CNT_W-1:0] CNT_END     = CNT_W'(SPRITE_COUNT);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state_q;
  logic [CNT_W-1:0] ptr_q;
  logic [7:0]       transp_q;
  logic [15:0]      qx_q, qy_q;

  // input word fields
  op_e         in_op;
  logic [17:0] in_addr;
  logic [7:0]  in_data;
  logic        in_acc;

  assign in_op   = op_e'(s_axis_tuser);
  assign in_addr = s_axis_tdata[17:0];
  assign in_data = s_axis_tdata[25:18];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // table row / lane from byte address
  logic [24:0] div_prod;
  logic [7:0]  wr_row;
  logic [11:0] row_x12;
  logic [11:0] lane_full;
  logic [3:0]  wr_lane;
  logic        tbl_wr;

  assign div_prod  = 25'(in_addr[11:0]) * RECIP_12;
  assign wr_row    = div_prod[RECIP_SHIFT +: 8];
  assign row_x12   = 12'({wr_row, 3'b000}) + 12'({wr_row, 2'b00});
  assign lane_full = in_addr[11:0] - row_x12;
  assign wr_lane   = lane_full[3:0];
  assign tbl_wr    = in_acc && (in_op == OP_TBL_WR) && (in_addr < TABLE_BYTES);

  logic             clearing;
  logic [IDX_W-1:0] tbl_waddr;
  logic [7:0]       tbl_wdata;
  logic [11:0]      tbl_we;
  logic [7:0]       lane_rd [RECORD_BYTES];

  assign clearing  = (state_q == ST_CLEAR);
  assign tbl_waddr = clearing ? ptr_q[IDX_W-1:0] : wr_row[IDX_W-1:0];
  assign tbl_wdata = clearing ? 8'd0 : in_data;

  for (genvar k = 0; k < RECORD_BYTES; k++) begin : g_lane
    assign tbl_we[k] = clearing || (tbl_wr && (wr_lane == 4'(k)));

    spc_ram #(
      .WIDTH(8),
      .DEPTH(SPRITE_COUNT)
    ) u_lane (
      .clk_i  (clk_i),
      .we_i   (tbl_we[k]),
      .waddr_i(tbl_waddr),
      .wdata_i(tbl_wdata),
      .raddr_i(ptr_q[IDX_W-1:0]),
      .rdata_o(lane_rd[k])
    );
  end

  // texel store
  logic [23:0]    wr_addr_ext;
  logic           tex_we;
  logic [TAW-1:0] tex_raddr;
  logic [7:0]     tex_rd;

  assign wr_addr_ext = 24'(in_addr);
  assign tex_we      = in_acc && (in_op == OP_TEX_WR);

  spc_ram #(
    .WIDTH(8),
    .DEPTH(1 << TEX_ADDR_BITS)
  ) u_tex (
    .clk_i  (clk_i),
    .we_i   (tex_we),
    .waddr_i(wr_addr_ext[TAW-1:0]),
    .wdata_i(in_data),
    .raddr_i(tex_raddr),
    .rdata_o(tex_rd)
  );

  // scan pipeline
  logic             v1_q, v2_q, v3_q, v4_q;
  logic [IDX_W-1:0] idx1_q, idx2_q, idx3_q, idx4_q;

  // stage A: record decode
  logic [15:0] sx, sy, dx, dy;
  logic [7:0]  wm1, hm1, flags;
  logic        cov_a;
  logic [7:0]  tx_a, ty_a;

  assign sx    = {lane_rd[B_X_HI], lane_rd[B_X_LO]};
  assign sy    = {lane_rd[B_Y_HI], lane_rd[B_Y_LO]};
  assign wm1   = lane_rd[B_WM1];
  assign hm1   = lane_rd[B_HM1];
  assign flags = lane_rd[B_FLAGS];
  assign dx    = qx_q - sx;
  assign dy    = qy_q - sy;
  assign cov_a = ((flags & FLAG_VISIBLE) != 8'd0) && (qx_q >= sx) && (qy_q >= sy) &&
                 (dx[15:8] == 8'd0) && (dy[15:8] == 8'd0) &&
                 (dx[7:0] <= wm1) && (dy[7:0] <= hm1);
  assign tx_a  = ((flags & FLAG_FLIPX) != 8'd0) ? (wm1 - dx[7:0]) : dx[7:0];
  assign ty_a  = ((flags & FLAG_FLIPY) != 8'd0) ? (hm1 - dy[7:0]) : dy[7:0];

  logic        cov2_q;
  logic [7:0]  tx2_q, ty2_q, pri2_q;
  logic [8:0]  w2_q;
  logic [23:0] off2_q;

  // stage B: row product and offset sum
  logic [16:0] prod_b;
  logic [24:0] offtx_b;
  assign prod_b  = 17'(ty2_q) * 17'(w2_q);
  assign offtx_b = 25'(off2_q) + 25'(tx2_q);

  logic        cov3_q;
  logic [7:0]  pri3_q;
  logic [16:0] prod3_q;
  logic [24:0] offtx3_q;

  // stage C: texel address
  logic [24:0] tsum;
  assign tsum      = offtx3_q + 25'(prod3_q);
  assign tex_raddr = tsum[TAW-1:0];

  logic       cov4_q;
  logic [7:0] pri4_q;

  // stage D: select
  logic draws, take;
  logic             hit_q;
  logic [7:0]       best_pri_q, best_col_q;
  logic [IDX_W-1:0] best_idx_q;

  assign draws = v4_q && cov4_q && (tex_rd != transp_q);
  assign take  = draws && (!hit_q || (pri4_q >= best_pri_q));

  logic m_valid_q;
  logic [23:0] m_data_q;
  logic pipe_busy;
  logic load_out;
  assign pipe_busy = v1_q || v2_q || v3_q || v4_q;
  assign load_out  = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      ptr_q     <= '0;
      transp_q  <= 8'd0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      hit_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        transp_q <= cfg_data_i;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      v1_q <= (state_q == ST_SCAN) && (ptr_q != CNT_END);
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (take) begin
        hit_q <= 1'b1;
      end
      case (state_q)
        ST_CLEAR: begin
          if (ptr_q == CNT_LAST) begin
            ptr_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_acc && (in_op == OP_QUERY)) begin
            ptr_q   <= '0;
            hit_q   <= 1'b0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (ptr_q != CNT_END) begin
            ptr_q <= ptr_q + 1'b1;
          end else if (!pipe_busy) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_op == OP_QUERY)) begin
      qx_q       <= s_axis_tdata[41:26];
      qy_q       <= s_axis_tdata[57:42];
      best_pri_q <= 8'd0;
      best_col_q <= 8'd0;
      best_idx_q <= '0;
    end else if (take) begin
      best_pri_q <= pri4_q;
      best_col_q <= tex_rd;
      best_idx_q <= idx4_q;
    end
    idx1_q   <= ptr_q[IDX_W-1:0];
    idx2_q   <= idx1_q;
    cov2_q   <= cov_a;
    tx2_q    <= tx_a;
    ty2_q    <= ty_a;
    w2_q     <= 9'(wm1) + 9'd1;
    off2_q   <= {lane_rd[B_OFF2], lane_rd[B_OFF1], lane_rd[B_OFF0]};
    pri2_q   <= lane_rd[B_PRI];
    idx3_q   <= idx2_q;
    cov3_q   <= cov2_q;
    pri3_q   <= pri2_q;
    prod3_q  <= prod_b;
    offtx3_q <= offtx_b;
    idx4_q   <= idx3_q;
    cov4_q   <= cov3_q;
    pri4_q   <= pri3_q;
    if (load_out) begin
      m_data_q <= {7'd0, 8'(best_idx_q), best_col_q, hit_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_no_tbl_wr_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (tbl_we == 12'd0))
    else $error("table written during scan");

  a_pipe_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_busy |-> (state_q == ST_SCAN))
    else $error("pipeline busy outside scan");

  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> !pipe_busy)
    else $error("result loaded before pipeline drained");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_data_q[0]) |-> (m_data_q[16:1] == 16'd0))
    else $error("miss carries nonzero colour or winner");

  a_clear_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CLEAR) && (ptr_q == CNT_LAST)) |=> (state_q == ST_IDLE))
    else $error("clearing pass did not end");

endmodule
